// ===== rtl/core/lsifs_pkg.sv =====
// ----------------------------------------------------------------------------
// lsifs_pkg
// Shared widths, operation and status codes, and cell control types for the
// bounded ordered list store.
// ----------------------------------------------------------------------------
package lsifs_pkg;

  localparam int OP_W           = 3;
  localparam int VAL_W          = 32;
  localparam int POS_W          = 5;
  localparam int STATUS_W       = 2;
  localparam int FPOS_W         = 4;
  localparam int CNT_OUT_W      = 5;
  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_INSERT = 3'd1,
    OP_POP    = 3'd2,
    OP_REMOVE = 3'd3,
    OP_CLEAR  = 3'd4,
    OP_FIND   = 3'd5,
    OP_SORT   = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_LOAD_VALUE,
    CMD_FROM_LEFT,
    CMD_FROM_RIGHT
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      descending;
  } cell_ctrl_t;

  typedef struct packed {
    logic match;      // entry equals the broadcast value
    logic order_bad;  // entry must move past its right neighbor
  } cell_stat_t;

endpackage

// ===== rtl/core/lsifs_in_if.sv =====
// ----------------------------------------------------------------------------
// lsifs_in_if
// Request channel of the list store: operation, value, position and order.
// ----------------------------------------------------------------------------
interface lsifs_in_if;
  import lsifs_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic signed [VAL_W-1:0] value;
  logic [POS_W-1:0]        position;
  logic                    descending;

  modport source (output valid, operation, value, position, descending, input ready);
  modport sink   (input valid, operation, value, position, descending, output ready);
endinterface

// ===== rtl/core/lsifs_out_if.sv =====
// ----------------------------------------------------------------------------
// lsifs_out_if
// Result channel of the list store: status, find outcome, count and empty flag.
// ----------------------------------------------------------------------------
interface lsifs_out_if;
  import lsifs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic                 found;
  logic [FPOS_W-1:0]    found_position;
  logic [CNT_OUT_W-1:0] count;
  logic                 is_empty;

  modport source (output valid, status, found, found_position, count, is_empty,
                  input ready);
  modport sink   (input valid, status, found, found_position, count, is_empty,
                  output ready);
endinterface

// ===== rtl/core/lsifs_cell.sv =====
// ----------------------------------------------------------------------------
// lsifs_cell
// One list entry: loads the broadcast value or a neighbor's entry, compares
// against the broadcast value and against its right neighbor.
// ----------------------------------------------------------------------------
module lsifs_cell #(
  parameter int DATA_WIDTH = lsifs_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  lsifs_pkg::cell_ctrl_t        ctrl,
  input  logic signed [DATA_WIDTH-1:0] value,
  input  logic signed [DATA_WIDTH-1:0] left_data,
  input  logic signed [DATA_WIDTH-1:0] right_data,
  output logic signed [DATA_WIDTH-1:0] data,
  output lsifs_pkg::cell_stat_t        stat
);
  import lsifs_pkg::*;

  logic signed [DATA_WIDTH-1:0] data_r;
  logic signed [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    case (ctrl.cmd)
      CMD_LOAD_VALUE: data_nxt = value;
      CMD_FROM_LEFT:  data_nxt = left_data;
      CMD_FROM_RIGHT: data_nxt = right_data;
      default:        data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data           = data_r;
  assign stat.match     = (data_r == value);
  assign stat.order_bad = ctrl.descending ? (data_r < right_data) : (data_r > right_data);

endmodule

// ===== rtl/core/list_store_insert_remove_find_sort.sv =====
// ----------------------------------------------------------------------------
// list_store_insert_remove_find_sort
// Bounded ordered list of signed entries held in a chain of cells.
// ----------------------------------------------------------------------------
// Push, insert, pop, remove, clear, find and unused codes post their result in
// the cycle after they are taken: every cell shifts or loads in parallel, and
// find matches all cells at once into a priority encoder. A request can be
// taken in every cycle while the result register is free or being drained.
// Sort runs odd-even compare and exchange steps between neighboring cells, one
// step per cycle, as many as the list holds entries (up to CAPACITY), then
// posts its result; fewer than two entries need no steps. No request is taken
// while a sort runs. Reset clears count, state, phase, out_valid, not entries.
// ----------------------------------------------------------------------------
module list_store_insert_remove_find_sort #(
  parameter int CAPACITY   = lsifs_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = lsifs_pkg::DATA_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  lsifs_in_if.sink  in_chan,
  lsifs_out_if.source out_chan
);
  import lsifs_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic {S_RUN, S_SORT} state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     phase_r, phase_nxt;
  logic                 desc_r, desc_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              status_r, status_nxt;
  logic                 found_r, found_nxt;
  logic [FPOS_W-1:0]    fpos_r, fpos_nxt;

  logic signed [DATA_WIDTH-1:0] data_q [CAPACITY];
  cell_ctrl_t                   ctrl   [CAPACITY];
  cell_stat_t                   stat   [CAPACITY];
  logic [CAPACITY-1:0]          hit;

  logic signed [DATA_WIDTH-1:0] val_ext;
  op_t                          op;
  logic                         in_fire;
  logic                         sort_step;
  logic                         sort_last;
  logic                         full;
  logic                         empty;
  logic [CMP_W-1:0]             pos_x;
  logic [CMP_W-1:0]             cnt_x;
  logic                         ok_push, ok_insert, ok_remove;
  logic [IDX_W+FPOS_W-1:0]      hit_idx_pad;
  logic [CNT_W+CNT_OUT_W-1:0]   count_pad;

  function automatic logic [IDX_W-1:0] lowest_hit(input logic [CAPACITY-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int k = CAPACITY - 1; k >= 0; k--) begin
      if (v[k]) r = IDX_W'(k);
    end
    return r;
  endfunction

  assign op        = op_t'(in_chan.operation);
  assign val_ext   = DATA_WIDTH'(in_chan.value);
  assign in_chan.ready = (state_r == S_RUN) && (!out_valid_r || out_chan.ready);
  assign in_fire   = in_chan.valid && in_chan.ready;
  assign sort_step = (state_r == S_SORT);
  assign sort_last = sort_step && (phase_r == count_r - 1'b1);
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign empty     = (count_r == '0);
  assign pos_x     = CMP_W'(in_chan.position);
  assign cnt_x     = CMP_W'(count_r);
  assign ok_push   = in_fire && (op == OP_PUSH) && !full;
  assign ok_insert = in_fire && (op == OP_INSERT) && !full && (pos_x <= cnt_x);
  assign ok_remove = in_fire && (op == OP_REMOVE) && !empty && (pos_x < cnt_x);

  // --- cell chain ---
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    logic signed [DATA_WIDTH-1:0] left_d, right_d;
    logic                         lo_swap, hi_swap;

    if (gi > 0) begin : g_left
      assign left_d  = data_q[gi-1];
      assign hi_swap = sort_step && (1'(gi - 1) == phase_r[0]) &&
                       (CNT_W'(gi) < count_r) && stat[gi-1].order_bad;
    end else begin : g_no_left
      assign left_d  = '0;
      assign hi_swap = 1'b0;
    end

    if (gi < CAPACITY - 1) begin : g_right
      assign right_d = data_q[gi+1];
    end else begin : g_no_right
      assign right_d = '0;
    end

    assign lo_swap = sort_step && (1'(gi) == phase_r[0]) &&
                     (CNT_W'(gi + 1) < count_r) && stat[gi].order_bad;

    always_comb begin
      ctrl[gi].descending = desc_r;
      ctrl[gi].cmd        = CMD_HOLD;
      if (ok_push && (CNT_W'(gi) == count_r)) begin
        ctrl[gi].cmd = CMD_LOAD_VALUE;
      end else if (ok_insert && (CMP_W'(gi) == pos_x)) begin
        ctrl[gi].cmd = CMD_LOAD_VALUE;
      end else if (ok_insert && (CMP_W'(gi) > pos_x) && (CNT_W'(gi) <= count_r)) begin
        ctrl[gi].cmd = CMD_FROM_LEFT;
      end else if (ok_remove && (CMP_W'(gi) >= pos_x) && (CNT_W'(gi + 1) < count_r)) begin
        ctrl[gi].cmd = CMD_FROM_RIGHT;
      end else if (lo_swap) begin
        ctrl[gi].cmd = CMD_FROM_RIGHT;
      end else if (hi_swap) begin
        ctrl[gi].cmd = CMD_FROM_LEFT;
      end
    end

    assign hit[gi] = stat[gi].match && (CNT_W'(gi) < count_r);

    lsifs_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
      .clk        (clk),
      .ctrl       (ctrl[gi]),
      .value      (val_ext),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (data_q[gi]),
      .stat       (stat[gi])
    );
  end

  assign hit_idx_pad = {{FPOS_W{1'b0}}, lowest_hit(hit)};

  // --- control and result ---
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    phase_nxt     = phase_r;
    desc_nxt      = desc_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    fpos_nxt      = fpos_r;

    if (out_valid_r && out_chan.ready) out_valid_nxt = 1'b0;

    if (in_fire) begin
      status_nxt    = ST_OK;
      found_nxt     = 1'b0;
      fpos_nxt      = '0;
      out_valid_nxt = 1'b1;
      case (op)
        OP_PUSH: begin
          if (full) status_nxt = ST_FULL;
          else      count_nxt  = count_r + 1'b1;
        end
        OP_INSERT: begin
          if (full)               status_nxt = ST_FULL;
          else if (pos_x > cnt_x) status_nxt = ST_RANGE;
          else                    count_nxt  = count_r + 1'b1;
        end
        OP_POP: begin
          if (empty) status_nxt = ST_EMPTY;
          else       count_nxt  = count_r - 1'b1;
        end
        OP_REMOVE: begin
          if (empty)               status_nxt = ST_EMPTY;
          else if (pos_x >= cnt_x) status_nxt = ST_RANGE;
          else                     count_nxt  = count_r - 1'b1;
        end
        OP_CLEAR: count_nxt = '0;
        OP_FIND: begin
          found_nxt = |hit;
          if (|hit) fpos_nxt = hit_idx_pad[FPOS_W-1:0];
        end
        OP_SORT: begin
          desc_nxt = in_chan.descending;
          // hold the result until the last exchange step
          if (count_r > CNT_W'(1)) begin
            state_nxt     = S_SORT;
            phase_nxt     = '0;
            out_valid_nxt = 1'b0;
          end
        end
        default: ;
      endcase
    end else if (sort_step) begin
      phase_nxt = phase_r + 1'b1;
      if (sort_last) begin
        state_nxt     = S_RUN;
        out_valid_nxt = 1'b1;
        status_nxt    = ST_OK;
        found_nxt     = 1'b0;
        fpos_nxt      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      count_r     <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
    desc_r   <= desc_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    fpos_r   <= fpos_nxt;
  end

  assign count_pad               = {{CNT_OUT_W{1'b0}}, count_r};
  assign out_chan.valid          = out_valid_r;
  assign out_chan.status         = status_r;
  assign out_chan.found          = found_r;
  assign out_chan.found_position = fpos_r;
  assign out_chan.count          = count_pad[CNT_OUT_W-1:0];
  assign out_chan.is_empty       = empty;

  // --- assertions ---
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_no_req_in_sort: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SORT) |-> (!in_chan.ready && !out_valid_r))
    else $error("request taken or result shown during sort");

  a_single_cycle_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (op != OP_SORT)) |=> out_valid_r)
    else $error("result missing after single-cycle request");

  a_sort_finish: assert property (@(posedge clk) disable iff (!rst_n)
    sort_last |=> (state_r == S_RUN) && out_valid_r)
    else $error("sort did not post its result");

endmodule
